[hw/rtl/sinl_pkg.sv]
`timescale 1ns / 1ps

package sinl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int POS_W  = 11;
    localparam int ID_W   = 32;
    localparam int MODE_W = 2;

    // Largest count the search can see: entry_count is clamped to the depth,
    // and the count field itself stops at 2**POS_W - 1.
    localparam int EFF_MAX = (TABLE_DEPTH < (1 << POS_W) - 1) ? TABLE_DEPTH
                                                             : (1 << POS_W) - 1;
    // Search bounds run from 0 up to EFF_MAX + 1
    localparam int SW        = $clog2(EFF_MAX + 2);
    // Worst-case probe count of the binary search
    localparam int NUM_CELLS = $clog2(EFF_MAX + 1);

    // Stream widths, rounded up to whole bytes
    localparam int IN_BITS  = CMD_W + POS_W + ID_W + MODE_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = POS_W + ID_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ID_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POS_QUERY = 2'd2;

    // Match modes
    localparam logic [MODE_W-1:0] MODE_EXACT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PREV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd2;

    // Search state handed from cell to cell
    typedef struct packed {
        logic            valid;
        logic            none;   // id 0 or empty table: answer is 0
        logic            over;   // search loop has ended
        logic            hit;
        logic [SW-1:0]   lo;
        logic [SW-1:0]   hi;
        logic [SW-1:0]   probe;
        logic [ID_W-1:0] seen;
    } srch_tok_t;

    // Table read request from one cell
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

endpackage

[hw/rtl/sinl_ram.sv]
`timescale 1ns / 1ps

module sinl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/sinl_cell.sv]
`timescale 1ns / 1ps

// One binary-search step: stage A issues the probe read, stage B compares.
module sinl_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sinl_pkg::ID_W-1:0]   key,
    input  sinl_pkg::srch_tok_t         tok_in,
    output sinl_pkg::rd_req_t           rd_req,
    input  logic [sinl_pkg::ID_W-1:0]   rd_data,
    output sinl_pkg::srch_tok_t         tok_out
);

    sinl_pkg::srch_tok_t      a_reg;
    sinl_pkg::srch_tok_t      b_reg;
    sinl_pkg::srch_tok_t      b_next;
    logic                     b_run_reg;
    logic                     run;
    logic [sinl_pkg::SW:0]    sum;
    logic [sinl_pkg::SW-1:0]  mid;
    logic [sinl_pkg::SW-1:0]  mid_m1;

    always_comb
    begin
        run    = a_reg.valid && !a_reg.over && (a_reg.lo <= a_reg.hi);
        sum    = {1'b0, a_reg.lo} + {1'b0, a_reg.hi};
        mid    = sum[sinl_pkg::SW:1];
        mid_m1 = mid - sinl_pkg::SW'(1);

        rd_req.en   = run;
        rd_req.addr = sinl_pkg::ADDR_W'(mid_m1);

        b_next = a_reg;
        if (run)
        begin
            b_next.probe = mid;
        end
        else if (a_reg.valid)
        begin
            b_next.over = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            b_reg     <= '0;
            b_run_reg <= 1'b0;
        end
        else
        begin
            a_reg     <= tok_in;
            b_reg     <= b_next;
            b_run_reg <= run;
        end
    end

    // Compare against the probe data and narrow the bounds
    always_comb
    begin
        tok_out = b_reg;
        if (b_run_reg)
        begin
            tok_out.seen = rd_data;
            if (rd_data == key)
            begin
                tok_out.hit  = 1'b1;
                tok_out.over = 1'b1;
            end
            else if (key > rd_data)
            begin
                tok_out.lo = b_reg.probe + sinl_pkg::SW'(1);
            end
            else
            begin
                tok_out.hi = b_reg.probe - sinl_pkg::SW'(1);
            end
        end
    end

endmodule

[hw/rtl/sorted_id_nearest_lookup_top.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: command, position, id_value, match_mode
// m_*       out  m_tvalid/m_tready    m_tdata: found_position, found_id
// cfg_*     in   cfg_we               cfg_wdata: entry_count
//
// One beat at a time. A load writes the table on accept. A position query
// returns its beat after one table read. An id query walks the row of
// NUM_CELLS search cells, each a probe read, then a compare, and its
// result is registered before it goes out on m_*.
// The table has a single read port, shared by the cells and position queries.
// Reset clears the count and all control state; table contents are not reset.
// s_tready drops while a query is in flight or a result sits unaccepted.
module sorted_id_nearest_lookup_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // [1:0] command, [12:2] position, [44:13] id_value, [46:45] match_mode
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sinl_pkg::IN_W-1:0]     s_tdata,
    // [10:0] found_position, [42:11] found_id
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sinl_pkg::OUT_W-1:0]    m_tdata,
    // entry_count
    input  logic                          cfg_we,
    input  logic [sinl_pkg::POS_W-1:0]    cfg_wdata
);

    // ---------------- input unpack ----------------
    localparam int POS_LSB  = sinl_pkg::CMD_W;
    localparam int ID_LSB   = POS_LSB + sinl_pkg::POS_W;
    localparam int MODE_LSB = ID_LSB + sinl_pkg::ID_W;

    logic [sinl_pkg::CMD_W-1:0]  command;
    logic [sinl_pkg::POS_W-1:0]  position;
    logic [sinl_pkg::ID_W-1:0]   id_value;
    logic [sinl_pkg::MODE_W-1:0] match_mode;

    assign command    = s_tdata[sinl_pkg::CMD_W-1:0];
    assign position   = s_tdata[ID_LSB-1:POS_LSB];
    assign id_value   = s_tdata[MODE_LSB-1:ID_LSB];
    assign match_mode = s_tdata[MODE_LSB+sinl_pkg::MODE_W-1:MODE_LSB];

    // ---------------- registers ----------------
    logic [sinl_pkg::POS_W-1:0]  entry_count_reg;
    logic [sinl_pkg::ID_W-1:0]   key_reg;
    logic [sinl_pkg::MODE_W-1:0] mode_reg;
    logic                        search_busy_reg;
    logic                        pos_busy_reg;
    logic                        pos_in_range_reg;
    logic                        out_valid_reg;
    logic [sinl_pkg::POS_W-1:0]  found_position_reg;
    logic [sinl_pkg::ID_W-1:0]   found_id_reg;

    logic accept;
    logic [sinl_pkg::SW-1:0]     eff_count;
    logic [sinl_pkg::POS_W-1:0]  pos_m1;
    logic                        pos_in_range;

    // Count above the depth acts as the depth
    assign eff_count = (int'(entry_count_reg) > sinl_pkg::TABLE_DEPTH)
                       ? sinl_pkg::SW'(sinl_pkg::TABLE_DEPTH)
                       : sinl_pkg::SW'(entry_count_reg);

    assign s_tready = !search_busy_reg && !pos_busy_reg && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign pos_m1   = position - sinl_pkg::POS_W'(1);
    assign pos_in_range = (position != '0) && (int'(position) <= int'(eff_count));

    // ---------------- table ----------------
    logic                        ram_we;
    logic [sinl_pkg::ADDR_W-1:0] ram_raddr;
    logic [sinl_pkg::ID_W-1:0]   ram_rdata;

    // Out-of-range loads are dropped; loads ignore entry_count
    assign ram_we = accept && (command == sinl_pkg::CMD_LOAD) && (position != '0)
                    && (int'(position) <= sinl_pkg::TABLE_DEPTH);

    sinl_pkg::srch_tok_t chain   [sinl_pkg::NUM_CELLS+1];
    sinl_pkg::rd_req_t   cell_req[sinl_pkg::NUM_CELLS];

    // Only one requester is active in any cycle
    always_comb
    begin
        ram_raddr = sinl_pkg::ADDR_W'(pos_m1);
        for (int k = 0; k < sinl_pkg::NUM_CELLS; k++)
        begin
            if (cell_req[k].en)
            begin
                ram_raddr = cell_req[k].addr;
            end
        end
    end

    sinl_ram #(
        .WIDTH (sinl_pkg::ID_W),
        .DEPTH (sinl_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sinl_pkg::ADDR_W'(pos_m1)),
        .wdata (id_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- search cell row ----------------
    // Start state: lo = 1, hi = count, probe = 1
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = accept && (command == sinl_pkg::CMD_ID_QUERY);
        chain[0].none  = (id_value == '0) || (eff_count == '0);
        chain[0].over  = chain[0].none;
        chain[0].lo    = sinl_pkg::SW'(1);
        chain[0].hi    = eff_count;
        chain[0].probe = sinl_pkg::SW'(1);
    end

    for (genvar g = 0; g < sinl_pkg::NUM_CELLS; g++)
    begin : g_cell
        sinl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .key     (key_reg),
            .tok_in  (chain[g]),
            .rd_req  (cell_req[g]),
            .rd_data (ram_rdata),
            .tok_out (chain[g+1])
        );
    end

    // ---------------- miss resolution ----------------
    sinl_pkg::srch_tok_t       fin;
    logic [sinl_pkg::SW-1:0]   answer;

    assign fin = chain[sinl_pkg::NUM_CELLS];

    always_comb
    begin
        answer = '0;
        if (fin.none)
        begin
            answer = '0;
        end
        else if (fin.hit)
        begin
            answer = fin.probe;
        end
        else
        begin
            case (mode_reg)
                sinl_pkg::MODE_PREV:
                begin
                    if (fin.seen < key_reg)
                    begin
                        answer = fin.probe;
                    end
                    else if (fin.probe == sinl_pkg::SW'(1))
                    begin
                        answer = '0;
                    end
                    else
                    begin
                        answer = fin.probe - sinl_pkg::SW'(1);
                    end
                end
                sinl_pkg::MODE_NEXT:
                begin
                    if ((fin.seen > key_reg) || (fin.probe == eff_count))
                    begin
                        answer = fin.probe;
                    end
                    else
                    begin
                        answer = fin.probe + sinl_pkg::SW'(1);
                    end
                end
                default:
                begin
                    answer = '0;
                end
            endcase
        end
    end

    // ---------------- control and output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg  <= '0;
            search_busy_reg  <= 1'b0;
            pos_busy_reg     <= 1'b0;
            pos_in_range_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            key_reg          <= '0;
            mode_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                entry_count_reg <= cfg_wdata;
            end

            if (accept)
            begin
                key_reg          <= id_value;
                mode_reg         <= match_mode;
                pos_in_range_reg <= pos_in_range;
            end

            if (accept && (command == sinl_pkg::CMD_ID_QUERY))
            begin
                search_busy_reg <= 1'b1;
            end
            else if (fin.valid)
            begin
                search_busy_reg <= 1'b0;
            end

            pos_busy_reg <= accept && (command == sinl_pkg::CMD_POS_QUERY);

            if (fin.valid || pos_busy_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            found_position_reg <= sinl_pkg::POS_W'(answer);
            found_id_reg       <= '0;
        end
        else if (pos_busy_reg)
        begin
            found_position_reg <= '0;
            found_id_reg       <= pos_in_range_reg ? ram_rdata : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sinl_pkg::OUT_W'({found_id_reg, found_position_reg});

endmodule
